### rtl/core/trdg_pkg.sv
// ----------------------------------------------------------------------------
// trdg_pkg
// shared types, codes and tables for the text row dot generator
// ----------------------------------------------------------------------------
package trdg_pkg;

  localparam int STORE_AW   = 11;
  localparam int CODE_W     = 8;
  localparam int ROW_W      = 4;
  localparam int BYTE_W     = 8;
  localparam int PATTERN_W  = 20;
  localparam int COUNT_W    = 5;
  localparam int COLOUR_W   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  // transaction kinds
  localparam logic KIND_RENDER   = 1'b0;
  localparam logic KIND_FONT_WR  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR_UNDERLINE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_REVERSE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_MODE    = 3'd4;

  // phosphor colour codes
  localparam logic [1:0] COLOUR_WHITE = 2'd0;
  localparam logic [1:0] COLOUR_GREEN = 2'd1;
  localparam logic [1:0] COLOUR_AMBER = 2'd2;

  localparam logic [ROW_W-1:0] UNDERLINE_ROW = 4'd8;

  // per cell controls travelling with a render transaction
  typedef struct packed {
    logic attr;
    logic wide;
    logic underline_row;
  } cell_ctl_t;

  // static cell shaping settings
  typedef struct packed {
    logic column_mode;
    logic attr_underline;
    logic screen_reverse;
  } cell_mode_t;

  // lit level 255*(31-b)/31, truncated
  function automatic logic [7:0] lit_level(logic [4:0] b);
    logic [7:0] v;
    case (b)
      5'd0:  v = 8'd255;
      5'd1:  v = 8'd246;
      5'd2:  v = 8'd238;
      5'd3:  v = 8'd230;
      5'd4:  v = 8'd222;
      5'd5:  v = 8'd213;
      5'd6:  v = 8'd205;
      5'd7:  v = 8'd197;
      5'd8:  v = 8'd189;
      5'd9:  v = 8'd180;
      5'd10: v = 8'd172;
      5'd11: v = 8'd164;
      5'd12: v = 8'd156;
      5'd13: v = 8'd148;
      5'd14: v = 8'd139;
      5'd15: v = 8'd131;
      5'd16: v = 8'd123;
      5'd17: v = 8'd115;
      5'd18: v = 8'd106;
      5'd19: v = 8'd98;
      5'd20: v = 8'd90;
      5'd21: v = 8'd82;
      5'd22: v = 8'd74;
      5'd23: v = 8'd65;
      5'd24: v = 8'd57;
      5'd25: v = 8'd49;
      5'd26: v = 8'd41;
      5'd27: v = 8'd32;
      5'd28: v = 8'd24;
      5'd29: v = 8'd16;
      5'd30: v = 8'd8;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/trdg_in_if.sv
// ----------------------------------------------------------------------------
// trdg_in_if
// input channel: render and font write transactions
// ----------------------------------------------------------------------------
interface trdg_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  char_code;
  logic        double_width;
  logic [3:0]  scan_row;
  logic [10:0] font_address;
  logic [7:0]  font_byte;

  modport source (
    output valid, kind, char_code, double_width, scan_row, font_address, font_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, char_code, double_width, scan_row, font_address, font_byte,
    output ready
  );
endinterface

### rtl/core/trdg_out_if.sv
// ----------------------------------------------------------------------------
// trdg_out_if
// result channel: dot pattern, dot count and dot colour of one cell row
// ----------------------------------------------------------------------------
interface trdg_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] dot_pattern;
  logic [4:0]  dot_count;
  logic [23:0] dot_colour;

  modport source (
    output valid, dot_pattern, dot_count, dot_colour,
    input  ready
  );
  modport sink (
    input  valid, dot_pattern, dot_count, dot_colour,
    output ready
  );
endinterface

### rtl/core/trdg_cell_fmt.sv
// ----------------------------------------------------------------------------
// trdg_cell_fmt
// turns one font row into the dots of a cell row: attribute, reverse,
// cell width shift, last column extension, dot stretch and doubling
// ----------------------------------------------------------------------------
module trdg_cell_fmt (
  input  logic [trdg_pkg::BYTE_W-1:0]    font_row,
  input  trdg_pkg::cell_ctl_t            ctl,
  input  trdg_pkg::cell_mode_t           mode,
  output logic [trdg_pkg::PATTERN_W-1:0] dot_pattern,
  output logic [trdg_pkg::COUNT_W-1:0]   dot_count
);

  function automatic logic [19:0] double_dots(logic [9:0] d);
    logic [19:0] r;
    r = '0;
    for (int i = 0; i < 10; i++) begin
      r[2*i]   = d[i];
      r[2*i+1] = d[i];
    end
    return r;
  endfunction

  logic [7:0]  row_dots;
  logic [9:0]  shifted;
  logic [9:0]  stretched;
  logic [19:0] sized;
  logic [19:0] mask;
  logic        invert;

  always_comb begin
    row_dots = (ctl.attr && mode.attr_underline && ctl.underline_row) ? 8'hFF : font_row;

    // place in the cell and copy the last font column into the extra columns
    if (mode.column_mode) begin
      shifted = {1'b0, row_dots, row_dots[0]};
    end else begin
      shifted = {row_dots, {2{row_dots[0]}}};
    end

    // dot stretcher
    stretched = shifted | (shifted >> 1);

    sized = ctl.wide ? double_dots(stretched) : {10'd0, stretched};

    case ({ctl.wide, mode.column_mode})
      2'b00:   mask = 20'h003FF;
      2'b01:   mask = 20'h001FF;
      2'b10:   mask = 20'hFFFFF;
      default: mask = 20'h3FFFF;
    endcase

    invert = (ctl.attr && !mode.attr_underline) ^ mode.screen_reverse;

    dot_pattern = (sized ^ (invert ? mask : 20'd0)) & mask;

    case ({ctl.wide, mode.column_mode})
      2'b00:   dot_count = 5'd10;
      2'b01:   dot_count = 5'd9;
      2'b10:   dot_count = 5'd20;
      default: dot_count = 5'd18;
    endcase
  end

endmodule

### rtl/core/text_row_dot_generator.sv
// ----------------------------------------------------------------------------
// text_row_dot_generator
// character generator with a 2048 x 8 font store, attribute handling,
// dot stretcher, double width and phosphor colour
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake           | contents
//  ---------+-----+---------------------+------------------------------------
//  in_ch    | in  | valid/ready         | kind, code, width, row, font write
//  out_ch   | out | valid/ready         | dot pattern, dot count, dot colour
//  cfg_*    | in  | cfg_we, no wait     | register index and data
//
//  one transaction per cycle while out_ch is not stalled; a render result
//  goes through the font store read register, then the output register
//  a font write goes through the store write port and gives no result
//  rst_n is synchronous; the font store is not cleared and holds garbage
//  until written
//  a stalled output holds the pipe: the render stage waits and in_ch.ready
//  drops only when the render stage cannot move on
//
module text_row_dot_generator (
  input  logic                               clk,
  input  logic                               rst_n,
  trdg_in_if.sink                            in_ch,
  trdg_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [trdg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trdg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int STORE_DEPTH = 2 ** trdg_pkg::STORE_AW;

  // configuration registers
  logic       column_mode_r;
  logic       attr_underline_r;
  logic       screen_reverse_r;
  logic [4:0] brightness_r;
  logic [1:0] colour_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_mode_r    <= 1'b0;
      attr_underline_r <= 1'b0;
      screen_reverse_r <= 1'b0;
      brightness_r     <= 5'd0;
      colour_mode_r    <= trdg_pkg::COLOUR_WHITE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        trdg_pkg::CFG_COLUMN_MODE:    column_mode_r    <= cfg_data[0];
        trdg_pkg::CFG_ATTR_UNDERLINE: attr_underline_r <= cfg_data[0];
        trdg_pkg::CFG_SCREEN_REVERSE: screen_reverse_r <= cfg_data[0];
        trdg_pkg::CFG_BRIGHTNESS:     brightness_r     <= cfg_data[4:0];
        trdg_pkg::CFG_COLOUR_MODE:    colour_mode_r    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_accept;
  logic do_render;
  logic do_font_wr;

  assign s1_adv     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_accept  = in_ch.valid && in_ch.ready;
  assign do_render  = in_accept && (in_ch.kind == trdg_pkg::KIND_RENDER);
  assign do_font_wr = in_accept && (in_ch.kind == trdg_pkg::KIND_FONT_WR);

  // font address: on scan row 0 the code steps to the next one first,
  // then 16 * code + row - 1 wraps round the store
  logic [trdg_pkg::CODE_W-1:0]   eff_code;
  logic [trdg_pkg::STORE_AW-1:0] rd_addr;

  always_comb begin
    eff_code = (in_ch.scan_row == '0) ? in_ch.char_code + 8'd1 : in_ch.char_code;
    rd_addr  = {eff_code[6:0], in_ch.scan_row} - 11'd1;
  end

  // font store, one write or one read per cycle, registered read data
  logic [trdg_pkg::BYTE_W-1:0] font_mem [STORE_DEPTH];
  logic [trdg_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (do_font_wr) begin
      font_mem[in_ch.font_address] <= in_ch.font_byte;
    end
    if (do_render) begin
      rd_data_r <= font_mem[rd_addr];
    end
  end

  // render stage: cell controls follow the read
  trdg_pkg::cell_ctl_t s1_ctl_r;
  trdg_pkg::cell_ctl_t s1_ctl_nxt;

  always_comb begin
    s1_ctl_nxt.attr          = eff_code[7];
    s1_ctl_nxt.wide          = in_ch.double_width;
    s1_ctl_nxt.underline_row = (in_ch.scan_row == trdg_pkg::UNDERLINE_ROW);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= do_render;
    end
  end

  always_ff @(posedge clk) begin
    if (do_render) begin
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  // dot shaping
  trdg_pkg::cell_mode_t              cell_mode;
  logic [trdg_pkg::PATTERN_W-1:0]    fmt_pattern;
  logic [trdg_pkg::COUNT_W-1:0]      fmt_count;

  assign cell_mode.column_mode    = column_mode_r;
  assign cell_mode.attr_underline = attr_underline_r;
  assign cell_mode.screen_reverse = screen_reverse_r;

  trdg_cell_fmt u_cell_fmt (
    .font_row    (rd_data_r),
    .ctl         (s1_ctl_r),
    .mode        (cell_mode),
    .dot_pattern (fmt_pattern),
    .dot_count   (fmt_count)
  );

  // lit dot colour; x/5 done as (x * 205) >> 10, exact below 1024
  logic [7:0]  level;
  logic [17:0] amber_prod;
  logic [17:0] green_prod;
  logic [7:0]  amber_green;
  logic [7:0]  green_blue;
  logic [trdg_pkg::COLOUR_W-1:0] colour;

  always_comb begin
    level       = trdg_pkg::lit_level(brightness_r);
    amber_prod  = {8'd0, level, 2'b00} * 18'd205;
    green_prod  = {10'd0, level} * 18'd205;
    amber_green = amber_prod[17:10];
    green_blue  = green_prod[17:10];
    case (colour_mode_r)
      trdg_pkg::COLOUR_AMBER: colour = {level, amber_green, 8'd0};
      trdg_pkg::COLOUR_GREEN: colour = {8'd0, level, green_blue};
      default:                colour = {level, level, level};
    endcase
  end

  // output register
  logic [trdg_pkg::PATTERN_W-1:0] pattern_r;
  logic [trdg_pkg::COUNT_W-1:0]   count_r;
  logic [trdg_pkg::COLOUR_W-1:0]  colour_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pattern_r <= fmt_pattern;
      count_r   <= fmt_count;
      colour_r  <= colour;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.dot_pattern = pattern_r;
  assign out_ch.dot_count   = count_r;
  assign out_ch.dot_colour  = colour_r;

  // a taken render always occupies the render stage next cycle
  a_render_enters: assert property (@(posedge clk) disable iff (!rst_n)
    do_render |=> s1_valid_r)
    else $error("render transaction lost before the render stage");

  // a font write never creates a result
  a_font_wr_silent: assert property (@(posedge clk) disable iff (!rst_n)
    do_font_wr |=> !s1_valid_r)
    else $error("font write produced a render stage entry");

  // an empty output register takes the waiting render at once
  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("render stage did not move into an empty output register");

  // narrow cells leave the top of the pattern clear
  a_narrow_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (count_r == 5'd9 || count_r == 5'd10)) |-> (pattern_r[19:10] == 10'd0))
    else $error("narrow cell with dots beyond its width");

  // dot count is one of the four cell widths
  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (count_r == 5'd9 || count_r == 5'd10 || count_r == 5'd18 ||
                     count_r == 5'd20))
    else $error("illegal dot count");

endmodule

### dv/text_row_dot_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_row_dot_generator_tb
// self-checking bench: writes font store entries, renders cell rows under many
// register settings and checks each dot row against a local prediction
// ----------------------------------------------------------------------------
module text_row_dot_generator_tb;

  // render result goes through font read and output register
  localparam int DRAIN_CYCLES = 4;
  // cycles without any accepted transaction before the run is abandoned
  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 156;
  localparam int MAX_REPORTS  = 10;
  // colour code outside the named phosphors, shows as white
  localparam logic [1:0] COLOUR_SPARE = 2'd3;

  // one input transaction, render or font write
  typedef struct {
    logic        kind;
    logic [7:0]  code;
    logic        wide;
    logic [3:0]  row;
    logic [10:0] addr;
    logic [7:0]  data;
  } glyph_req_t;

  // one expected dot row
  typedef struct packed {
    logic [trdg_pkg::PATTERN_W-1:0] pattern;
    logic [trdg_pkg::COUNT_W-1:0]   count;
    logic [trdg_pkg::COLOUR_W-1:0]  colour;
  } dot_row_t;

  typedef enum int {RX_STEADY, RX_COIN, RX_BURSTY, RX_PERIODIC} rx_mode_t;

  logic clk;
  logic rst_n;
  logic                            cfg_we;
  logic [trdg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [trdg_pkg::CFG_DATA_W-1:0] cfg_data;

  trdg_in_if  in_ch();
  trdg_out_if out_ch();

  text_row_dot_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // local copy of the font store and of the register file
  logic [7:0]  font_mirror [0:2047];
  bit          font_written [0:2047];
  int          written_addrs[$];
  logic [10:0] last_font_addr;
  logic        column_mode;
  logic        attr_underline;
  logic        screen_reverse;
  logic [4:0]  brightness;
  logic [1:0]  colour_mode;

  dot_row_t pending_dot_rows[$];
  int       mismatches;
  int       idle_cycles;
  int       burst_left;
  bit       sender_steady;

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // dot row prediction from the local font copy and register copy
  // ---------------------------------------------------------------------------
  function automatic dot_row_t predict_dot_row(logic [7:0] code_in, logic wide,
                                               logic [3:0] row);
    logic [7:0]  code;
    logic [10:0] addr;
    logic [19:0] dots;
    logic [19:0] doubled;
    logic [19:0] mask;
    logic [19:0] inv;
    int          shift;
    int          cell_dots;
    int          level;
    int          i;
    dot_row_t    r;
    // row 0 fetches through the following code, address wraps in the store
    code = code_in;
    if (row == 4'd0) code = code + 8'd1;
    addr = {code[6:0], row} - 11'd1;
    dots = 20'(font_mirror[addr]);
    shift     = column_mode ? 1 : 2;
    cell_dots = column_mode ? 9 : 10;
    if (wide) mask = column_mode ? 20'h3FFFF : 20'hFFFFF;
    else      mask = column_mode ? 20'h001FF : 20'h003FF;
    // attribute bit: underline on its row, or reverse the whole cell
    inv = '0;
    if (code[7]) begin
      if (attr_underline) begin
        if (row == trdg_pkg::UNDERLINE_ROW) dots = 20'h000FF;
      end else begin
        inv = mask;
      end
    end
    if (screen_reverse) inv ^= mask;
    // place in the cell, extend the last font column, stretch dots right
    dots = dots << shift;
    if (dots[shift]) dots |= (20'd1 << shift) - 20'd1;
    dots |= dots >> 1;
    if (wide) begin
      doubled = '0;
      for (i = 0; i < 10; i++) begin
        if (dots[i]) doubled[2*i +: 2] = 2'b11;
      end
      dots = doubled;
    end
    r.pattern = (dots ^ inv) & mask;
    r.count   = wide ? 5'(2 * cell_dots) : 5'(cell_dots);
    level = (255 * (31 - int'(brightness))) / 31;
    case (colour_mode)
      trdg_pkg::COLOUR_AMBER: r.colour = {8'(level), 8'((level * 8) / 10), 8'h00};
      trdg_pkg::COLOUR_GREEN: r.colour = {8'h00, 8'(level), 8'((level * 2) / 10)};
      default:                r.colour = {8'(level), 8'(level), 8'(level)};
    endcase
    return r;
  endfunction

  // font write with random don't-care render fields
  function automatic glyph_req_t font_write_item(logic [10:0] addr, logic [7:0] data);
    glyph_req_t req;
    req.kind = trdg_pkg::KIND_FONT_WR;
    req.code = 8'($urandom);
    req.wide = 1'($urandom);
    req.row  = 4'($urandom);
    req.addr = addr;
    req.data = data;
    return req;
  endfunction

  // render with random don't-care font write fields
  function automatic glyph_req_t render_item(logic [7:0] code, logic wide, logic [3:0] row);
    glyph_req_t req;
    req.kind = trdg_pkg::KIND_RENDER;
    req.code = code;
    req.wide = wide;
    req.row  = row;
    req.addr = 11'($urandom);
    req.data = 8'($urandom);
    return req;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: bursts of random length, random gaps in between
  // valid stays high from one transaction of a burst to the next
  // ---------------------------------------------------------------------------
  task automatic send_item(input glyph_req_t req);
    int gap;
    if (burst_left == 0) begin
      gap = sender_steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_ch.kind         = req.kind;
    in_ch.char_code    = req.code;
    in_ch.double_width = req.wide;
    in_ch.scan_row     = req.row;
    in_ch.font_address = req.addr;
    in_ch.font_byte    = req.data;
    in_ch.valid        = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // transaction taken: update the local store or queue the expected row
    if (req.kind == trdg_pkg::KIND_FONT_WR) begin
      font_mirror[req.addr] = req.data;
      if (!font_written[req.addr]) begin
        font_written[req.addr] = 1'b1;
        written_addrs.push_back(int'(req.addr));
      end
      last_font_addr = req.addr;
    end else begin
      pending_dot_rows.push_back(predict_dot_row(req.code, req.wide, req.row));
    end
  endtask

  // stop sending and let every result and any font write settle
  task automatic drain_pipe;
    @(negedge clk);
    in_ch.valid = 1'b0;
    burst_left  = 0;
    while (pending_dot_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write, only called while the block is idle
  task automatic write_reg(input logic [trdg_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [trdg_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    case (idx)
      trdg_pkg::CFG_COLUMN_MODE:    column_mode    = data[0];
      trdg_pkg::CFG_ATTR_UNDERLINE: attr_underline = data[0];
      trdg_pkg::CFG_SCREEN_REVERSE: screen_reverse = data[0];
      trdg_pkg::CFG_BRIGHTNESS:     brightness     = data[4:0];
      trdg_pkg::CFG_COLOUR_MODE:    colour_mode    = data[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings: store address wrap, row 0 fetch, attribute reverse,
  // and a render right behind a write to the same entry
  task automatic test_address_wrap;
    send_item(font_write_item(11'd15, 8'h81));
    send_item(font_write_item(11'd2047, 8'hC3));
    send_item(font_write_item(11'd0, 8'hFF));
    send_item(font_write_item(11'd135, 8'h00));
    send_item(render_item(8'h00, 1'b0, 4'd0));   // reads the row before its own
    send_item(render_item(8'hFF, 1'b1, 4'd0));   // code wraps to 0, address to the top
    send_item(render_item(8'h7F, 1'b0, 4'd0));   // increment sets the attribute bit
    send_item(render_item(8'h88, 1'b0, trdg_pkg::UNDERLINE_ROW));
    send_item(render_item(8'h00, 1'b0, 4'd1));
    send_item(font_write_item(11'd15, 8'h55));
    send_item(render_item(8'h00, 1'b0, 4'd0));   // read after write
  endtask

  // every register at its extremes, 132 columns, wide cells, spare colour code
  task automatic test_register_extremes;
    drain_pipe();
    write_reg(trdg_pkg::CFG_COLUMN_MODE, 5'd1);
    write_reg(trdg_pkg::CFG_ATTR_UNDERLINE, 5'd1);
    write_reg(trdg_pkg::CFG_SCREEN_REVERSE, 5'd1);
    write_reg(trdg_pkg::CFG_BRIGHTNESS, 5'd31);
    write_reg(trdg_pkg::CFG_COLOUR_MODE, 5'(trdg_pkg::COLOUR_AMBER));
    send_item(render_item(8'h88, 1'b0, trdg_pkg::UNDERLINE_ROW));
    send_item(render_item(8'h88, 1'b1, trdg_pkg::UNDERLINE_ROW));
    send_item(render_item(8'hFF, 1'b1, 4'd0));   // wide 132-column cell, 18 dots
    send_item(render_item(8'h00, 1'b1, 4'd1));
    drain_pipe();
    write_reg(trdg_pkg::CFG_COLUMN_MODE, 5'd0);
    write_reg(trdg_pkg::CFG_SCREEN_REVERSE, 5'd0);
    write_reg(trdg_pkg::CFG_BRIGHTNESS, 5'd0);
    write_reg(trdg_pkg::CFG_COLOUR_MODE, 5'(COLOUR_SPARE));
    send_item(render_item(8'h88, 1'b1, trdg_pkg::UNDERLINE_ROW));
    send_item(render_item(8'h7F, 1'b0, 4'd0));   // attribute underline off its row
    drain_pipe();
    write_reg(trdg_pkg::CFG_ATTR_UNDERLINE, 5'd0);
    write_reg(trdg_pkg::CFG_SCREEN_REVERSE, 5'd1);
    write_reg(trdg_pkg::CFG_BRIGHTNESS, 5'd17);
    write_reg(trdg_pkg::CFG_COLOUR_MODE, 5'(trdg_pkg::COLOUR_GREEN));
    send_item(render_item(8'h7F, 1'b1, 4'd0));   // attribute and screen reverse cancel
    send_item(render_item(8'h00, 1'b0, 4'd0));
  endtask

  // random phases: new settings each phase, mixed font writes and renders
  // that only ever fetch entries already written
  task automatic test_random_traffic;
    int          phase;
    int          n;
    logic [10:0] a;
    logic [10:0] t;
    logic [7:0]  fetched;
    for (phase = 0; phase < PHASES; phase++) begin
      drain_pipe();
      write_reg(trdg_pkg::CFG_COLUMN_MODE, 5'($urandom_range(0, 1)));
      write_reg(trdg_pkg::CFG_ATTR_UNDERLINE, 5'($urandom_range(0, 1)));
      write_reg(trdg_pkg::CFG_SCREEN_REVERSE, 5'($urandom_range(0, 1)));
      case ($urandom_range(0, 3))
        0:       write_reg(trdg_pkg::CFG_BRIGHTNESS, 5'd0);
        1:       write_reg(trdg_pkg::CFG_BRIGHTNESS, 5'd31);
        default: write_reg(trdg_pkg::CFG_BRIGHTNESS, 5'($urandom_range(0, 31)));
      endcase
      write_reg(trdg_pkg::CFG_COLOUR_MODE, 5'($urandom_range(0, 3)));
      sender_steady = ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 35) begin
          send_item(font_write_item(11'($urandom), 8'($urandom)));
        end else begin
          // pick a written entry, sometimes the one just written
          if ($urandom_range(0, 4) == 0) a = last_font_addr;
          else a = 11'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
          // work back from the entry to the code and row that fetch it
          t = a + 11'd1;
          fetched = {1'($urandom), t[10:4]};
          if (t[3:0] == 4'd0) fetched = fetched - 8'd1;
          send_item(render_item(fetched, 1'($urandom), t[3:0]));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: ready pattern picks a new mode at random after each span of cycles
  // ---------------------------------------------------------------------------
  initial begin
    rx_mode_t mode;
    int       span;
    int       period;
    int       stall_left;
    int       n;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      mode   = rx_mode_t'($urandom_range(0, 3));
      span   = $urandom_range(20, 120);
      period = $urandom_range(2, 5);
      for (n = 0; n < span; n++) begin
        @(negedge clk);
        case (mode)
          RX_STEADY: out_ch.ready = 1'b1;
          RX_COIN:   out_ch.ready = 1'($urandom);
          RX_BURSTY: begin
            if (stall_left > 0) begin
              out_ch.ready = 1'b0;
              stall_left--;
            end else if ($urandom_range(0, 15) == 0) begin
              out_ch.ready = 1'b0;
              stall_left   = $urandom_range(1, 12);
            end else begin
              out_ch.ready = 1'b1;
            end
          end
          default: out_ch.ready = (n % period == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result check: each accepted dot row against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_rows
    dot_row_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_dot_rows.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected dot row pattern=%h count=%0d colour=%h", $realtime,
                   out_ch.dot_pattern, out_ch.dot_count, out_ch.dot_colour);
        mismatches++;
      end else begin
        want = pending_dot_rows.pop_front();
        if (out_ch.dot_pattern !== want.pattern || out_ch.dot_count !== want.count ||
            out_ch.dot_colour !== want.colour) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: dot row mismatch exp %h/%0d/%h got %h/%0d/%h",
                     $realtime, want.pattern, want.count, want.colour,
                     out_ch.dot_pattern, out_ch.dot_count, out_ch.dot_colour);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: cycles in a row with no transaction on either channel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    @(posedge clk);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("text_row_dot_generator_tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // all inputs known from time zero while reset is held
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = trdg_pkg::KIND_RENDER;
    in_ch.char_code    = '0;
    in_ch.double_width = 1'b0;
    in_ch.scan_row     = '0;
    in_ch.font_address = '0;
    in_ch.font_byte    = '0;
    // register copy starts at the reset values
    column_mode        = 1'b0;
    attr_underline     = 1'b0;
    screen_reverse     = 1'b0;
    brightness         = 5'd0;
    colour_mode        = trdg_pkg::COLOUR_WHITE;
    last_font_addr     = '0;
    mismatches         = 0;
    burst_left         = 0;
    sender_steady      = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_address_wrap();
    test_register_extremes();
    test_random_traffic();
    drain_pipe();

    if (mismatches == 0 && pending_dot_rows.size() == 0) begin
      $display("text_row_dot_generator_tb passed");
    end else begin
      $display("text_row_dot_generator_tb failed");
    end
    $finish;
  end

endmodule
